// ----- hw/rtl/mwie_pkg.sv -----
// mwie_pkg: opcodes, field widths and shared types for the memory word
// instruction executor. No dependencies.
`default_nettype none

package mwie_pkg;

  localparam int WORD_W = 32;
  localparam int KIND_W = 3;
  localparam int CFG_W  = 11;

  localparam int DATA_WORDS_DEF  = 1024;
  localparam int INSTR_WORDS_DEF = 1024;

  localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NEG = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_JPA = 3'd3;
  localparam logic [KIND_W-1:0] KIND_JP0 = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ASI = 3'd5;
  localparam logic [KIND_W-1:0] KIND_LOE = 3'd6;
  localparam logic [KIND_W-1:0] KIND_HLT = 3'd7;

  typedef struct packed {
    logic halted;
    logic jump_err;
    logic data_err;
    logic wrote;
  } exec_flags_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mwie_exec.sv -----
// mwie_exec: execute logic for one instruction, given the operand words
// already read from data memory. Uses mwie_pkg.
`default_nettype none

module mwie_exec #(
  parameter int DATA_WORDS  = mwie_pkg::DATA_WORDS_DEF,
  parameter int INSTR_WORDS = mwie_pkg::INSTR_WORDS_DEF,
  parameter int AW          = $clog2(DATA_WORDS),
  parameter int PW          = $clog2(INSTR_WORDS + 1)
) (
  input  logic [mwie_pkg::KIND_W-1:0] kind,
  input  logic [mwie_pkg::WORD_W-1:0] op_a,
  input  logic [mwie_pkg::WORD_W-1:0] op_b,
  input  logic [mwie_pkg::WORD_W-1:0] op_c,
  input  logic [mwie_pkg::WORD_W-1:0] word_x,
  input  logic [mwie_pkg::WORD_W-1:0] word_y,
  input  logic [PW-1:0]               pc,
  input  logic                        stopped,
  input  logic [mwie_pkg::CFG_W-1:0]  program_length,
  output logic [PW-1:0]               next_pc,
  output mwie_pkg::exec_flags_t       flags,
  output logic [AW-1:0]               write_addr,
  output logic [mwie_pkg::WORD_W-1:0] write_value
);
  import mwie_pkg::*;

  logic              a_ok, b_ok, c_ok, a_ij, b_ij;
  logic [PW-1:0]     len, pc_inc;
  logic [WORD_W-1:0] prod;

  always_comb begin
    a_ok   = op_a < WORD_W'(DATA_WORDS);
    b_ok   = op_b < WORD_W'(DATA_WORDS);
    c_ok   = op_c < WORD_W'(DATA_WORDS);
    a_ij   = op_a < WORD_W'(INSTR_WORDS);
    b_ij   = op_b < WORD_W'(INSTR_WORDS);
    len    = (WORD_W'(program_length) > WORD_W'(INSTR_WORDS)) ?
             PW'(INSTR_WORDS) : PW'(program_length);
    pc_inc = pc + PW'(1);
    prod   = word_x * word_y;

    next_pc        = pc_inc;
    flags.halted   = stopped;
    flags.jump_err = 1'b0;
    flags.data_err = 1'b0;
    flags.wrote    = 1'b0;
    write_addr     = op_c[AW-1:0];
    write_value    = '0;

    if (stopped || pc >= len) begin
      // nothing runs, counter holds
      next_pc      = pc;
      flags.halted = 1'b1;
    end else begin
      case (kind)
        KIND_ADD, KIND_MUL, KIND_LOE: begin
          flags.data_err = !(a_ok && b_ok && c_ok);
          write_addr     = op_c[AW-1:0];
          if (kind == KIND_ADD) begin
            write_value = word_x + word_y;
          end else if (kind == KIND_MUL) begin
            write_value = prod;
          end else begin
            write_value = ($signed(word_x) <= $signed(word_y)) ? WORD_W'(1) : '0;
          end
          flags.wrote = !flags.data_err;
        end
        KIND_NEG: begin
          flags.data_err = !(a_ok && b_ok);
          write_addr     = op_b[AW-1:0];
          write_value    = WORD_W'(0) - word_x;
          flags.wrote    = !flags.data_err;
        end
        KIND_ASI: begin
          flags.data_err = !b_ok;
          write_addr     = op_b[AW-1:0];
          write_value    = op_a;
          flags.wrote    = !flags.data_err;
        end
        KIND_JPA: begin
          if (a_ij) begin
            next_pc = op_a[PW-1:0];
          end else begin
            flags.jump_err = 1'b1;
          end
        end
        KIND_JP0: begin
          flags.data_err = !a_ok;
          if (!b_ij) begin
            flags.jump_err = 1'b1;
          end else if (a_ok && word_x == '0) begin
            next_pc = op_b[PW-1:0];
          end
        end
        default: begin
          // hlt
          next_pc      = len;
          flags.halted = 1'b1;
        end
      endcase
      if (next_pc >= len) begin
        flags.halted = 1'b1;
      end
    end

    if (!flags.wrote) begin
      write_addr  = '0;
      write_value = '0;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/memory_word_instruction_executor.sv -----
// Executes decoded instructions one at a time against a private data memory
// of DATA_WORDS words, keeping the program counter and the halted flag.
// Each input item is the instruction at the current program counter
// (kind and three operands). Each item gives exactly one result item: the
// next program counter, the halted flag, range error flags and the data
// write it made, if any.
// Both channels use valid/stall; an item moves at a clock edge with valid
// high and stall low. cfg_write_en loads program_length at any edge with rst_n high.
// Timing: operand words are read from the data memory at the edge that
// accepts the item; the result is registered when the execute stage
// advances. The write-back happens at that same edge, and a bypass
// register covers the next item's reads, so one item is accepted every
// cycle while the receiver does not stall. The rate is set by the
// memory's read port pair feeding the execute stage and its single write port.
// A receiver stall holds the result register; the execute stage then holds
// its item and in_stall rises until the result is taken.
// Reset (rst_n low, synchronous) clears the counter, halted state and
// program_length, then a clearing pass zeroes the data memory one word a
// cycle, from word 0 up to DATA_WORDS-1, during which in_stall stays high.
`default_nettype none

module memory_word_instruction_executor #(
  parameter int DATA_WORDS  = mwie_pkg::DATA_WORDS_DEF,
  parameter int INSTR_WORDS = mwie_pkg::INSTR_WORDS_DEF,
  parameter int AW          = $clog2(DATA_WORDS),
  parameter int PW          = $clog2(INSTR_WORDS + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_write_en,
  input  logic [mwie_pkg::CFG_W-1:0]         cfg_write_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mwie_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [mwie_pkg::WORD_W-1:0] in_operand_a,
  input  logic signed [mwie_pkg::WORD_W-1:0] in_operand_b,
  input  logic signed [mwie_pkg::WORD_W-1:0] in_operand_c,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [PW-1:0]                      out_next_pc,
  output logic                               out_halted,
  output logic                               out_jump_range_error,
  output logic                               out_data_addr_error,
  output logic                               out_wrote,
  output logic [AW-1:0]                      out_write_addr,
  output logic signed [mwie_pkg::WORD_W-1:0] out_write_value
);
  import mwie_pkg::*;

  logic [WORD_W-1:0] mem [DATA_WORDS];
  logic [WORD_W-1:0] rd_a_r, rd_b_r;

  logic              clr_active_r, clr_active_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;

  logic [CFG_W-1:0]  prog_len_r;
  logic [PW-1:0]     pc_r;
  logic              stopped_r;

  logic              s1_valid_r, s1_valid_nxt;
  logic [KIND_W-1:0] s1_kind_r;
  logic [WORD_W-1:0] s1_a_r, s1_b_r, s1_c_r;

  logic              fwd_valid_r;
  logic [AW-1:0]     fwd_addr_r;
  logic [WORD_W-1:0] fwd_data_r;

  logic              out_valid_r, out_valid_nxt;
  logic [PW-1:0]     out_pc_r;
  exec_flags_t       out_flags_r;
  logic [AW-1:0]     out_waddr_r;
  logic [WORD_W-1:0] out_wval_r;

  logic              in_acc, s1_adv;
  logic [WORD_W-1:0] word_x, word_y;
  logic [PW-1:0]     ex_next_pc;
  exec_flags_t       ex_flags;
  logic [AW-1:0]     ex_waddr;
  logic [WORD_W-1:0] ex_wval;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clr_active_r || (s1_valid_r && !s1_adv);
  assign in_acc   = in_valid && !in_stall;

  // bypass the write made at the edge that read this item's operands
  assign word_x = (fwd_valid_r && fwd_addr_r == s1_a_r[AW-1:0]) ? fwd_data_r : rd_a_r;
  assign word_y = (fwd_valid_r && fwd_addr_r == s1_b_r[AW-1:0]) ? fwd_data_r : rd_b_r;

  mwie_exec #(
    .DATA_WORDS (DATA_WORDS),
    .INSTR_WORDS(INSTR_WORDS),
    .AW         (AW),
    .PW         (PW)
  ) u_exec (
    .kind          (s1_kind_r),
    .op_a          (s1_a_r),
    .op_b          (s1_b_r),
    .op_c          (s1_c_r),
    .word_x        (word_x),
    .word_y        (word_y),
    .pc            (pc_r),
    .stopped       (stopped_r),
    .program_length(prog_len_r),
    .next_pc       (ex_next_pc),
    .flags         (ex_flags),
    .write_addr    (ex_waddr),
    .write_value   (ex_wval)
  );

  assign mem_we    = clr_active_r || (s1_adv && ex_flags.wrote);
  assign mem_waddr = clr_active_r ? clr_cnt_r : ex_waddr;
  assign mem_wdata = clr_active_r ? '0 : ex_wval;

  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_cnt_nxt    = clr_cnt_r;
    if (clr_active_r) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(DATA_WORDS - 1)) begin
        clr_active_nxt = 1'b0;
      end
    end

    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rd_a_r <= mem[in_operand_a[AW-1:0]];
      rd_b_r <= mem[in_operand_b[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
      prog_len_r   <= '0;
      pc_r         <= '0;
      stopped_r    <= 1'b0;
      s1_valid_r   <= 1'b0;
      fwd_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_write_en) begin
        prog_len_r <= cfg_write_data;
      end
      if (s1_adv) begin
        pc_r      <= ex_next_pc;
        stopped_r <= ex_flags.halted;
        if (ex_flags.wrote) begin
          fwd_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r <= in_kind;
      s1_a_r    <= in_operand_a;
      s1_b_r    <= in_operand_b;
      s1_c_r    <= in_operand_c;
    end
    if (s1_adv) begin
      out_pc_r    <= ex_next_pc;
      out_flags_r <= ex_flags;
      out_waddr_r <= ex_waddr;
      out_wval_r  <= ex_wval;
      if (ex_flags.wrote) begin
        fwd_addr_r <= ex_waddr;
        fwd_data_r <= ex_wval;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_next_pc          = out_pc_r;
  assign out_halted           = out_flags_r.halted;
  assign out_jump_range_error = out_flags_r.jump_err;
  assign out_data_addr_error  = out_flags_r.data_err;
  assign out_wrote            = out_flags_r.wrote;
  assign out_write_addr       = out_waddr_r;
  assign out_write_value      = out_wval_r;

`ifndef ASSERT_OFF
  // no item may enter while the memory is being cleared
  a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> (in_stall && !s1_valid_r && !out_valid_r))
    else $error("item in flight during memory clear");

  // once stopped, executing an item leaves the counter where it was
  a_stopped_pc_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && stopped_r) |=> (pc_r == $past(pc_r) && stopped_r))
    else $error("program counter moved while stopped");

  // a reported write never carries a data address error
  a_write_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_flags_r.wrote) |-> !out_flags_r.data_err)
    else $error("write reported with data address error");

  // the result register is loaded only when the execute stage advances
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !s1_valid_r) |=> !out_valid_r)
    else $error("result appeared without an item in execute");
`endif

endmodule

`default_nettype wire

// ----- tb/mwie_tb_pkg.sv -----
// mwie_tb_pkg: instruction and result item types plus the scoreboard class
// that predicts each result of the instruction executor.
// Depends on mwie_pkg for opcodes and field widths.
`timescale 1ns / 1ps

package mwie_tb_pkg;
  import mwie_pkg::*;

  localparam int          MEM_WORDS = 1024;
  localparam logic [10:0] PC_LIMIT  = 11'd1024;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] opa;
    logic [WORD_W-1:0] opb;
    logic [WORD_W-1:0] opc;
  } instr_t;

  typedef struct packed {
    logic [10:0]       next_pc;
    logic              halted;
    logic              jump_err;
    logic              data_err;
    logic              wrote;
    logic [9:0]        write_addr;
    logic [WORD_W-1:0] write_value;
  } exec_result_t;

  class exec_scoreboard;
    logic [WORD_W-1:0] data_mem [MEM_WORDS];
    logic [10:0]       pc;
    logic [10:0]       prog_len;
    bit                stopped;
    exec_result_t      predicted_results[$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      foreach (data_mem[i]) data_mem[i] = '0;
      pc       = '0;
      prog_len = '0;
      stopped  = 1'b0;
      errors   = 0;
      checked  = 0;
    endfunction

    // lengths above the instruction store act as a full store
    function logic [10:0] eff_len();
      return (prog_len > PC_LIMIT) ? PC_LIMIT : prog_len;
    endfunction

    function void set_length(logic [10:0] v);
      prog_len = v;
    endfunction

    function bit addr_ok(logic [WORD_W-1:0] v);
      return v[WORD_W-1:10] == '0;
    endfunction

    function void predict_instr(instr_t it);
      exec_result_t      r;
      logic [10:0]       lim;
      logic [10:0]       nxt;
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] val;
      logic [9:0]        dst;
      bit                jerr;
      bit                derr;
      bit                wr;
      r    = '0;
      lim  = eff_len();
      jerr = 1'b0;
      derr = 1'b0;
      wr   = 1'b0;
      val  = '0;
      dst  = '0;
      // nothing runs once stopped or past the end of the program
      if (stopped || pc >= lim) begin
        stopped   = 1'b1;
        r.next_pc = pc;
        r.halted  = 1'b1;
        predicted_results.push_back(r);
        return;
      end
      nxt = pc + 11'd1;
      x   = addr_ok(it.opa) ? data_mem[it.opa[9:0]] : '0;
      y   = addr_ok(it.opb) ? data_mem[it.opb[9:0]] : '0;
      case (it.kind)
        KIND_ADD, KIND_MUL, KIND_LOE: begin
          derr = !addr_ok(it.opa) || !addr_ok(it.opb) || !addr_ok(it.opc);
          dst  = it.opc[9:0];
          if (it.kind == KIND_ADD) val = x + y;
          else if (it.kind == KIND_MUL) val = x * y;
          else val = ($signed(x) <= $signed(y)) ? 32'd1 : 32'd0;
          wr = !derr;
        end
        KIND_NEG: begin
          derr = !addr_ok(it.opa) || !addr_ok(it.opb);
          dst  = it.opb[9:0];
          val  = 32'd0 - x;
          wr   = !derr;
        end
        KIND_ASI: begin
          derr = !addr_ok(it.opb);
          dst  = it.opb[9:0];
          val  = it.opa;
          wr   = !derr;
        end
        KIND_JPA: begin
          if (addr_ok(it.opa)) nxt = {1'b0, it.opa[9:0]};
          else jerr = 1'b1;
        end
        KIND_JP0: begin
          derr = !addr_ok(it.opa);
          if (!addr_ok(it.opb)) jerr = 1'b1;
          else if (!derr && x == '0) nxt = {1'b0, it.opb[9:0]};
        end
        default: begin
          nxt     = lim;
          stopped = 1'b1;
        end
      endcase
      if (wr) begin
        data_mem[dst] = val;
      end else begin
        dst = '0;
        val = '0;
      end
      if (nxt >= lim) stopped = 1'b1;
      pc            = nxt;
      r.next_pc     = nxt;
      r.halted      = stopped;
      r.jump_err    = jerr;
      r.data_err    = derr;
      r.wrote       = wr;
      r.write_addr  = dst;
      r.write_value = val;
      predicted_results.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      // keep the log short when the block is badly off
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task cmp_field(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %0h, want %0h", checked, name, got, want));
    endtask

    task check_result(exec_result_t got);
      exec_result_t want;
      checked++;
      if (predicted_results.size() == 0) begin
        report($sformatf("result %0d arrived with none pending", checked));
        return;
      end
      want = predicted_results.pop_front();
      cmp_field("next_pc", 32'(got.next_pc), 32'(want.next_pc));
      cmp_field("halted", 32'(got.halted), 32'(want.halted));
      cmp_field("jump_range_error", 32'(got.jump_err), 32'(want.jump_err));
      cmp_field("data_addr_error", 32'(got.data_err), 32'(want.data_err));
      cmp_field("wrote", 32'(got.wrote), 32'(want.wrote));
      cmp_field("write_addr", 32'(got.write_addr), 32'(want.write_addr));
      cmp_field("write_value", got.write_value, want.write_value);
    endtask
  endclass

endpackage

// ----- tb/tb.sv -----
// tb: top of the instruction executor testbench; drives instructions and
// program lengths, stalls the result side and checks every result item.
// Depends on mwie_pkg, mwie_tb_pkg and memory_word_instruction_executor.
`timescale 1ns / 1ps

module tb;
  import mwie_pkg::*;
  import mwie_tb_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              cfg_write_en;
  logic [CFG_W-1:0]  cfg_write_data;
  logic              in_valid;
  logic              in_stall;
  logic [KIND_W-1:0] in_kind;
  logic [WORD_W-1:0] in_operand_a;
  logic [WORD_W-1:0] in_operand_b;
  logic [WORD_W-1:0] in_operand_c;
  logic              out_valid;
  logic              out_stall;
  logic [10:0]       out_next_pc;
  logic              out_halted;
  logic              out_jump_range_error;
  logic              out_data_addr_error;
  logic              out_wrote;
  logic [9:0]        out_write_addr;
  logic [WORD_W-1:0] out_write_value;

  exec_scoreboard sb;
  exec_result_t   seen_result;
  bit             send_burst;

  memory_word_instruction_executor u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_write_en         (cfg_write_en),
    .cfg_write_data       (cfg_write_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_operand_a         (in_operand_a),
    .in_operand_b         (in_operand_b),
    .in_operand_c         (in_operand_c),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_next_pc          (out_next_pc),
    .out_halted           (out_halted),
    .out_jump_range_error (out_jump_range_error),
    .out_data_addr_error  (out_data_addr_error),
    .out_wrote            (out_wrote),
    .out_write_addr       (out_write_addr),
    .out_write_value      (out_write_value)
  );

  assign seen_result = {out_next_pc, out_halted, out_jump_range_error,
                        out_data_addr_error, out_wrote, out_write_addr,
                        out_write_value};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(seen_result);
  end

  // result side: random hold-offs, bursts without any, two long stretches
  initial begin : result_side
    int unsigned gap;
    int unsigned taken;
    bit          burst;
    taken = 0;
    burst = 1'b0;
    out_stall <= 1'b1;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 19);
      if (taken == 30 || taken == 450) gap = 200;
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      taken++;
    end
  end

  task automatic send_instr(input logic [KIND_W-1:0] k, input logic [WORD_W-1:0] a,
                            input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] c);
    int unsigned gap;
    instr_t      it;
    it.kind = k;
    it.opa  = a;
    it.opb  = b;
    it.opc  = c;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= k;
    in_operand_a <= a;
    in_operand_b <= b;
    in_operand_c <= c;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.predict_instr(it);
  endtask

  // program length is only changed with the block drained
  task automatic write_length(input logic [10:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.predicted_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    sb.set_length(v);
  endtask

  function automatic logic [WORD_W-1:0] pick_addr();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 62) return 32'($urandom_range(0, 15));
    else if (r < 76) return 32'($urandom_range(1008, 1023));
    else if (r < 94) return 32'($urandom_range(0, 1023));
    else if (r < 96) return 32'd1024 + 32'($urandom_range(0, 31));
    else if (r < 98) return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
    else return $urandom;
  endfunction

  function automatic logic [WORD_W-1:0] pick_imm();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom;
    else if (r < 70) return 32'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return 32'h0;
    endcase
  endfunction

  // jump targets stay clear of the program end; the rest are out of range
  function automatic logic [WORD_W-1:0] pick_target(input logic [10:0] lim);
    if ($urandom_range(0, 9) != 0) return 32'($urandom_range(0, 32'(lim) - 4));
    if ($urandom_range(0, 1) == 0) return 32'd1024 + 32'($urandom_range(0, 63));
    return $urandom | 32'h8000_0000;
  endfunction

  function automatic instr_t gen_instr();
    instr_t      it;
    logic [10:0] lim;
    int unsigned r;
    lim    = sb.eff_len();
    it.opa = pick_addr();
    it.opb = pick_addr();
    it.opc = pick_addr();
    r      = $urandom_range(0, 99);
    if (sb.pc + 11'd3 >= lim) begin
      // near the end: jump back so the program keeps running
      it.kind = KIND_JPA;
      it.opa  = 32'($urandom_range(0, 32'(lim) / 2));
    end else if (r < 12) begin
      it.kind = 3'($urandom_range(0, 6));
      it.opa  = $urandom;
      it.opb  = $urandom;
      it.opc  = $urandom;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 18) it.kind = KIND_ADD;
      else if (r < 30) it.kind = KIND_NEG;
      else if (r < 44) it.kind = KIND_MUL;
      else if (r < 64) begin
        it.kind = KIND_ASI;
        it.opa  = pick_imm();
      end else if (r < 78) it.kind = KIND_LOE;
      else if (r < 86) begin
        it.kind = KIND_JPA;
        it.opa  = pick_target(lim);
      end else begin
        it.kind = KIND_JP0;
        it.opb  = pick_target(lim);
      end
    end
    return it;
  endfunction

  task automatic run_random(input int unsigned n);
    instr_t it;
    for (int unsigned i = 0; i < n; i++) begin
      it = gen_instr();
      send_instr(it.kind, it.opa, it.opb, it.opc);
    end
  endtask

  task automatic run_directed();
    send_instr(KIND_ASI, 32'h7FFF_FFFF, 32'd0, 32'd0);
    send_instr(KIND_ASI, 32'h8000_0000, 32'd1, 32'd0);
    send_instr(KIND_ASI, 32'hFFFF_FFFF, 32'd1023, 32'd0);
    send_instr(KIND_ADD, 32'd0, 32'd1, 32'd2);
    send_instr(KIND_ADD, 32'd0, 32'd0, 32'd3);        // signed overflow wraps
    send_instr(KIND_MUL, 32'd0, 32'd1, 32'd4);
    send_instr(KIND_MUL, 32'd1023, 32'd1023, 32'd5);
    send_instr(KIND_NEG, 32'd1, 32'd6, 32'd0);        // most negative stays put
    send_instr(KIND_NEG, 32'd0, 32'd7, 32'd0);
    send_instr(KIND_LOE, 32'd1, 32'd0, 32'd8);
    send_instr(KIND_LOE, 32'd0, 32'd1, 32'd9);
    send_instr(KIND_LOE, 32'd1023, 32'd1023, 32'd10);
    send_instr(KIND_ADD, 32'd0, 32'd1, 32'd1024);     // bad destination
    send_instr(KIND_ADD, 32'hFFFF_FFFF, 32'd1, 32'd12);
    send_instr(KIND_NEG, 32'd0, 32'h8000_0000, 32'd0);
    send_instr(KIND_ASI, 32'h1234_5678, 32'd1024, 32'd0);
    send_instr(KIND_LOE, 32'd0, 32'hFFFF_FFFF, 32'd13);
    send_instr(KIND_JP0, 32'd11, 32'd20, 32'd0);      // word is zero: taken
    send_instr(KIND_JP0, 32'd0, 32'd5, 32'd0);        // nonzero: falls through
    send_instr(KIND_JP0, 32'd1024, 32'd3, 32'd0);     // bad tested address
    send_instr(KIND_JP0, 32'd11, 32'd1024, 32'd0);    // bad target
    send_instr(KIND_JP0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_instr(KIND_JPA, 32'd1024, 32'd0, 32'd0);
    send_instr(KIND_JPA, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_instr(KIND_JPA, 32'd1023, 32'd0, 32'd0);
    send_instr(KIND_JPA, 32'd0, 32'd0, 32'd0);
  endtask

  // stop the program one of three ways, then feed a stopped block
  task automatic wind_down();
    logic [10:0] lim;
    logic [10:0] cut;
    lim = sb.eff_len();
    case ($urandom_range(0, 2))
      0: send_instr(KIND_HLT, $urandom, $urandom, $urandom);
      1: begin
        send_instr(KIND_JPA, 32'(lim - 11'd1), $urandom, $urandom);
        send_instr(KIND_ASI, $urandom, 32'd0, $urandom);
      end
      default: begin
        cut = 11'($urandom_range(0, 32'(lim) - 1));
        send_instr(KIND_JPA, 32'(cut), $urandom, $urandom);
        write_length(cut);
      end
    endcase
    for (int i = 0; i < 12; i++)
      send_instr(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
    write_length(11'd0);
    for (int i = 0; i < 5; i++)
      send_instr(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
  endtask

  initial begin : stimulus
    sb             = new();
    send_burst     = 1'b0;
    rst_n          <= 1'b0;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= '0;
    in_valid       <= 1'b0;
    in_kind        <= '0;
    in_operand_a   <= '0;
    in_operand_b   <= '0;
    in_operand_c   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    write_length(11'd2047);
    run_directed();
    run_random(300);
    write_length(11'd1024);
    run_random(300);
    // back to the start so a shorter program still holds the counter
    send_instr(KIND_JPA, 32'd0, $urandom, $urandom);
    write_length(11'($urandom_range(64, 1000)));
    run_random(300);
    wind_down();
    in_valid <= 1'b0;
    while (sb.predicted_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/mwie_pkg.sv
hw/rtl/mwie_exec.sv
hw/rtl/memory_word_instruction_executor.sv
tb/mwie_tb_pkg.sv
tb/tb.sv
